>>> sv/assert_macros.svh
// assertion macros shared by the vertex transform block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/vtb_pkg.sv
// shared widths and constants for the vertex transform block
// no dependencies
package vtb_pkg;

  localparam int COORD_FRAC_BITS = 16;

  localparam int NUM_REGS  = 6;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 64;
  localparam int COORD_W   = 32;
  localparam int NORM_W    = 16;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CS_W   = 63;

  localparam int IN_DATA_W  = 3 * COORD_W + 3 * NORM_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 9 * COORD_W + 3 * NORM_W;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam logic [COORD_W-1:0] FX_ONE = COORD_W'(1) << COORD_FRAC_BITS;

  // identity matrix, zero translation
  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    {FX_ONE, {COORD_W{1'b0}}},
    {REG_W{1'b0}},
    {{COORD_W{1'b0}}, FX_ONE},
    {REG_W{1'b0}},
    {REG_W{1'b0}},
    {FX_ONE, {COORD_W{1'b0}}}
  };

endpackage

>>> sv/vertex_transform_bbox.sv
// vertex transform top level: sequencer, matrix registers, bounding box, output register
// depends on vtb_pkg, vtb_mul, vtb_csub and assert_macros.svh
//
// one vertex per item on the in_ channel; one result per item on the out_ channel.
// the matrix is loaded through cfg_we / cfg_index / cfg_wdata; the user must do so only
// while the block is idle, which the block does not enforce; indexes above five are ignored.
// in_tready is high only when the sequencer is idle; a vertex is then taken and worked
// through a single 33x33 multiplier and a shared compare-subtract unit.
// position: twelve products, after which an item without a normal goes to the output.
// with a normal: nine more products, a one-bit-per-cycle normalising shifter (a normal
// of zero length goes from there to the output), three squares, a 32-step square root
// and three 15-step divisions.
// the result sits in an output register; if out_tready is low the sequencer waits in
// its last state and the block takes no new item until the register frees up.
// reset (rst_n low, synchronous) loads the identity matrix, clears the bounding box to
// zero in every axis and drops out_tvalid.
`include "assert_macros.svh"

module vertex_transform_bbox import vtb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // first_vertex, has_normal
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_pos_x/y/z, out_norm_x/y/z, box_min_x/y/z, box_max_x/y/z
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  reg_idx_t              cfg_index,
  input  logic [REG_W-1:0]      cfg_wdata
);

  localparam int RN_W    = 50;
  localparam int A_W     = RN_W - 1;
  localparam int NRM_TOP = 30;
  localparam int SQ_W    = 62;
  localparam int RES_W   = SQ_W + 1;
  localparam int LEN_W   = 31;
  localparam int Q_SHIFT = 14;
  localparam int Q_W     = Q_SHIFT + 1;
  localparam int DIV_W   = LEN_W + Q_SHIFT;

  localparam logic [1:0] COL_LAST_POS = 2'd3;
  localparam logic [1:0] COL_LAST_VEC = 2'd2;
  localparam logic [1:0] ROW_LAST     = 2'd2;
  localparam logic [1:0] COMP_LAST    = 2'd2;

  localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (COORD_FRAC_BITS - 1);
  localparam logic signed [MUL_W-1:0]  TRANS_ONE = MUL_W'(1) << COORD_FRAC_BITS;
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [RES_W-1:0] SQRT_BIT0 = RES_W'(1) << (RES_W - 1);
  localparam logic [Q_W-1:0]   Q_MAX     = Q_W'(1) << Q_SHIFT;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_POS  = 10'b0000000010,
    S_NMUL = 10'b0000000100,
    S_ABS  = 10'b0000001000,
    S_NORM = 10'b0000010000,
    S_SQ   = 10'b0000100000,
    S_SQRT = 10'b0001000000,
    S_DSET = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]  norm_z;
    logic signed [NORM_W-1:0]  norm_y;
    logic signed [NORM_W-1:0]  norm_x;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_x;
  } in_data_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_max_z;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_min_z;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_min_x;
    logic signed [NORM_W-1:0]  out_norm_z;
    logic signed [NORM_W-1:0]  out_norm_y;
    logic signed [NORM_W-1:0]  out_norm_x;
    logic signed [COORD_W-1:0] out_pos_z;
    logic signed [COORD_W-1:0] out_pos_y;
    logic signed [COORD_W-1:0] out_pos_x;
  } out_data_t;

  state_t state_r, state_nxt;

  logic [REG_W-1:0] cfg_r [NUM_REGS];

  logic signed [COORD_W-1:0] pos_r [3];
  logic signed [NORM_W-1:0]  nrm_r [3];
  logic                      first_r;
  logic                      has_nrm_r;

  logic [1:0] row_i_r, col_i_r;
  logic       iss_done_r;
  logic       mv_r, mlast_r, mfinal_r;
  logic [1:0] mrow_r, mcol_r;

  logic signed [PROD_W-1:0]  acc_r;
  logic signed [COORD_W-1:0] tp_r [3];
  logic signed [RN_W-1:0]    rn_r [3];
  logic [A_W-1:0]            a_r [3];
  logic                      neg_r [3];

  logic [SQ_W-1:0]  v_r;
  logic [RES_W-1:0] res_r, bit_r;
  logic [DIV_W-1:0] rem_r, dv_r;
  logic [Q_W-1:0]   q_r;
  logic [3:0]       dcnt_r;
  logic [1:0]       comp_r;
  logic [Q_W-1:0]   on_mag_r [3];

  logic signed [COORD_W-1:0] box_lo_r [3];
  logic signed [COORD_W-1:0] box_hi_r [3];
  logic signed [COORD_W-1:0] box_lo_nxt [3];
  logic signed [COORD_W-1:0] box_hi_nxt [3];

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  in_data_t  in_d;
  out_data_t out_d;

  logic       in_acc, out_load;
  logic       issuing, iss_last_col;
  logic [1:0] last_col, last_row;
  logic [REG_W-1:0]   mat_word;
  logic [COORD_W-1:0] mat_sel;
  logic signed [MUL_W-1:0]  op_a, op_b, sq_op;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_init, acc_sum, pos_sh;
  logic                     pos_fit;
  logic [COORD_W-1:0]       pos_sat;
  logic nrm_hi, nrm_b29, nrm_zero;
  logic [CS_W-1:0] cs_x, cs_y, cs_res;
  logic            cs_ge;
  logic [LEN_W-1:0] len;
  logic [Q_W-1:0]   q_nxt;
  logic signed [NORM_W-1:0] onv [3];

  assign in_d      = in_data_t'(in_tdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // multiplier issue
  assign last_col     = (state_r == S_POS) ? COL_LAST_POS : COL_LAST_VEC;
  assign last_row     = (state_r == S_SQ) ? '0 : ROW_LAST;
  assign issuing      = (state_r == S_POS || state_r == S_NMUL || state_r == S_SQ)
                        && !iss_done_r;
  assign iss_last_col = (col_i_r == last_col);

  assign mat_word = cfg_r[{row_i_r, col_i_r[1]}];
  assign mat_sel  = col_i_r[0] ? mat_word[COORD_W-1:0] : mat_word[REG_W-1:COORD_W];
  assign sq_op    = {{(MUL_W-NRM_TOP){1'b0}}, a_r[col_i_r][NRM_TOP-1:0]};

  always_comb begin
    op_a = {mat_sel[COORD_W-1], mat_sel};
    op_b = {pos_r[col_i_r][COORD_W-1], pos_r[col_i_r]};
    case (state_r)
      S_POS: begin
        if (col_i_r == COL_LAST_POS) begin
          op_b = TRANS_ONE;
        end
      end
      S_NMUL: begin
        op_b = MUL_W'(nrm_r[col_i_r]);
      end
      S_SQ: begin
        op_a = sq_op;
        op_b = sq_op;
      end
      default: ;
    endcase
  end

  vtb_mul u_mul (
    .clk    (clk),
    .en     (issuing),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // accumulate and round
  assign acc_init = (state_r == S_POS) ? ROUND_ADD : '0;
  assign acc_sum  = ((mcol_r == '0) ? acc_init : acc_r) + prod_r;
  assign pos_sh   = acc_sum >>> COORD_FRAC_BITS;
  assign pos_fit  = (&pos_sh[PROD_W-1:COORD_W-1]) | ~(|pos_sh[PROD_W-1:COORD_W-1]);
  assign pos_sat  = pos_fit ? pos_sh[COORD_W-1:0]
                            : (pos_sh[PROD_W-1] ? COORD_MIN : COORD_MAX);

  // normalising shifter status
  assign nrm_hi   = |{a_r[0][A_W-1:NRM_TOP], a_r[1][A_W-1:NRM_TOP], a_r[2][A_W-1:NRM_TOP]};
  assign nrm_b29  = a_r[0][NRM_TOP-1] | a_r[1][NRM_TOP-1] | a_r[2][NRM_TOP-1];
  assign nrm_zero = ~|{a_r[0], a_r[1], a_r[2]};

  // square root and division step
  assign cs_x = (state_r == S_SQRT) ? CS_W'(v_r) : CS_W'(rem_r);
  assign cs_y = (state_r == S_SQRT) ? CS_W'(res_r | bit_r) : CS_W'(dv_r);

  vtb_csub u_csub (
    .x   (cs_x),
    .y   (cs_y),
    .ge  (cs_ge),
    .res (cs_res)
  );

  assign len   = res_r[LEN_W-1:0];
  assign q_nxt = {q_r[Q_W-2:0], cs_ge};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_POS;
      end
      S_POS: begin
        if (mv_r && mfinal_r) state_nxt = has_nrm_r ? S_NMUL : S_OUT;
      end
      S_NMUL: begin
        if (mv_r && mfinal_r) state_nxt = S_ABS;
      end
      S_ABS: begin
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (nrm_zero) state_nxt = S_OUT;
        else if (!nrm_hi && nrm_b29) state_nxt = S_SQ;
      end
      S_SQ: begin
        if (mv_r && mfinal_r) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (bit_r[0]) state_nxt = S_DSET;
      end
      S_DSET: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dcnt_r == '0) state_nxt = (comp_r == COMP_LAST) ? S_OUT : S_DSET;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result assembly and bounding box
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      onv[j] = neg_r[j] ? -{1'b0, on_mag_r[j]} : {1'b0, on_mag_r[j]};
      if (first_r) begin
        box_lo_nxt[j] = tp_r[j];
        box_hi_nxt[j] = tp_r[j];
      end else begin
        box_lo_nxt[j] = (tp_r[j] < box_lo_r[j]) ? tp_r[j] : box_lo_r[j];
        box_hi_nxt[j] = (tp_r[j] > box_hi_r[j]) ? tp_r[j] : box_hi_r[j];
      end
    end
    out_d.out_pos_x  = tp_r[0];
    out_d.out_pos_y  = tp_r[1];
    out_d.out_pos_z  = tp_r[2];
    out_d.out_norm_x = onv[0];
    out_d.out_norm_y = onv[1];
    out_d.out_norm_z = onv[2];
    out_d.box_min_x  = box_lo_nxt[0];
    out_d.box_min_y  = box_lo_nxt[1];
    out_d.box_min_z  = box_lo_nxt[2];
    out_d.box_max_x  = box_hi_nxt[0];
    out_d.box_max_y  = box_hi_nxt[1];
    out_d.box_max_z  = box_hi_nxt[2];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      mv_r         <= 1'b0;
      iss_done_r   <= 1'b0;
      row_i_r      <= '0;
      col_i_r      <= '0;
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= REG_RESET[i];
      for (int j = 0; j < 3; j++) begin
        box_lo_r[j] <= '0;
        box_hi_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      mv_r    <= issuing;
      if (cfg_we && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
        cfg_r[cfg_index] <= cfg_wdata;
      end
      if (state_nxt != state_r) begin
        row_i_r    <= '0;
        col_i_r    <= '0;
        iss_done_r <= 1'b0;
      end else if (issuing) begin
        if (iss_last_col) begin
          col_i_r <= '0;
          if (row_i_r == last_row) iss_done_r <= 1'b1;
          else row_i_r <= row_i_r + 2'd1;
        end else begin
          col_i_r <= col_i_r + 2'd1;
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        for (int j = 0; j < 3; j++) begin
          box_lo_r[j] <= box_lo_nxt[j];
          box_hi_r[j] <= box_hi_nxt[j];
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mrow_r   <= row_i_r;
    mcol_r   <= col_i_r;
    mlast_r  <= iss_last_col;
    mfinal_r <= iss_last_col && (row_i_r == last_row);

    if (in_acc) begin
      pos_r[0]  <= in_d.pos_x;
      pos_r[1]  <= in_d.pos_y;
      pos_r[2]  <= in_d.pos_z;
      nrm_r[0]  <= in_d.norm_x;
      nrm_r[1]  <= in_d.norm_y;
      nrm_r[2]  <= in_d.norm_z;
      first_r   <= in_tuser[0];
      has_nrm_r <= in_tuser[1];
      for (int j = 0; j < 3; j++) on_mag_r[j] <= '0;
    end

    if (out_load) begin
      out_tdata_r <= out_d;
    end

    if (mv_r) begin
      acc_r <= acc_sum;
      if (mlast_r) begin
        case (state_r)
          S_POS:  tp_r[mrow_r] <= pos_sat;
          S_NMUL: rn_r[mrow_r] <= acc_sum[RN_W-1:0];
          S_SQ: begin
            v_r    <= acc_sum[SQ_W-1:0];
            res_r  <= '0;
            bit_r  <= SQRT_BIT0;
            comp_r <= '0;
          end
          default: ;
        endcase
      end
    end

    case (state_r)
      S_ABS: begin
        for (int j = 0; j < 3; j++) begin
          neg_r[j] <= rn_r[j][RN_W-1];
          a_r[j]   <= rn_r[j][RN_W-1] ? A_W'(-rn_r[j]) : A_W'(rn_r[j]);
        end
      end
      S_NORM: begin
        if (!nrm_zero) begin
          if (nrm_hi) begin
            for (int j = 0; j < 3; j++) a_r[j] <= a_r[j] >> 1;
          end else if (!nrm_b29) begin
            for (int j = 0; j < 3; j++) a_r[j] <= a_r[j] << 1;
          end
        end
      end
      S_SQRT: begin
        if (cs_ge) begin
          v_r   <= cs_res[SQ_W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_DSET: begin
        rem_r  <= DIV_W'({a_r[0][NRM_TOP-1:0], {Q_SHIFT{1'b0}}}) + DIV_W'(len[LEN_W-1:1]);
        dv_r   <= {len, {Q_SHIFT{1'b0}}};
        q_r    <= '0;
        dcnt_r <= 4'(Q_W - 1);
        // rotate so the next component sits in lane zero
        a_r[0] <= a_r[1];
        a_r[1] <= a_r[2];
        a_r[2] <= a_r[0];
      end
      S_DIV: begin
        rem_r <= cs_res[DIV_W-1:0];
        q_r   <= q_nxt;
        dv_r  <= dv_r >> 1;
        if (dcnt_r == '0) begin
          on_mag_r[2] <= q_nxt;
          on_mag_r[1] <= on_mag_r[2];
          on_mag_r[0] <= on_mag_r[1];
          comp_r      <= comp_r + 2'd1;
        end else begin
          dcnt_r <= dcnt_r - 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_acc, !in_tready, "ready high after an item was taken")
  `ASSERT_IMPLIES(a_box_order, clk, rst_n, 1'b1, (box_lo_r[0] <= box_hi_r[0]) && (box_lo_r[1] <= box_hi_r[1]) && (box_lo_r[2] <= box_hi_r[2]), "bounding box minimum above maximum")
  `ASSERT_IMPLIES(a_norm_range, clk, rst_n, state_r == S_SQ, nrm_b29 && !nrm_hi, "normal not normalised before squaring")
  `ASSERT_IMPLIES(a_unit_bound, clk, rst_n, state_r == S_OUT, (on_mag_r[0] <= Q_MAX) && (on_mag_r[1] <= Q_MAX) && (on_mag_r[2] <= Q_MAX), "unit normal component above one")

endmodule

>>> sv/vtb_mul.sv
// shared signed multiplier with registered product
// depends on vtb_pkg
module vtb_mul import vtb_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule

>>> sv/vtb_csub.sv
// shared compare and restoring subtract step for square root and division
// depends on vtb_pkg
module vtb_csub import vtb_pkg::*; (
  input  logic [CS_W-1:0] x,
  input  logic [CS_W-1:0] y,
  output logic            ge,
  output logic [CS_W-1:0] res
);

  logic [CS_W:0] diff;

  assign diff = {1'b0, x} - {1'b0, y};
  assign ge   = ~diff[CS_W];
  assign res  = ge ? diff[CS_W-1:0] : x;

endmodule

>>> test/vertex_transform_bbox_tb.sv
`timescale 1ns / 1ps
// self-checking bench for vertex_transform_bbox: directed corner vertices, then random meshes
// under a series of matrices, with random stalls on both streams; needs vtb_pkg and the rtl
module vertex_transform_bbox_tb;
  import vtb_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RANDOM_PHASES   = 8;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 50;
  localparam int MAX_GAP         = 6;
  localparam int MAX_PRINTED     = 40;
  localparam int NORM_FRAC_BITS  = 14;
  localparam int NORM_PEAK_BIT   = 29;

  typedef logic [REG_W-1:0]   matrix_regs_t [NUM_REGS];
  typedef logic [COORD_W-1:0] entry_grid_t [3][4];
  typedef enum int {STYLE_SMALL, STYLE_ROTATION, STYLE_FULL} matrix_style_t;

  typedef struct packed {
    logic                         has_normal;
    logic                         first_vertex;
    logic [2:0][NORM_W-1:0]       nrm;
    logic [2:0][COORD_W-1:0]      pos;
  } vertex_t;

  // same layout as out_tdata, lowest field last
  typedef struct packed {
    logic [2:0][COORD_W-1:0] hi;
    logic [2:0][COORD_W-1:0] lo;
    logic [2:0][NORM_W-1:0]  nrm;
    logic [2:0][COORD_W-1:0] pos;
  } vertex_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  reg_idx_t              cfg_index = '0;
  logic [REG_W-1:0]      cfg_wdata = '0;

  bit          in_steady = 1'b0;
  bit          out_steady = 1'b0;
  int unsigned settings_loaded = 0;
  int unsigned idle_cycles = 0;

  class vertex_scoreboard;
    logic [REG_W-1:0]          mreg [NUM_REGS];
    logic signed [COORD_W-1:0] box_lo [3];
    logic signed [COORD_W-1:0] box_hi [3];
    vertex_result_t            expected_q [$];
    int unsigned errors, checked, vertices, with_normal, zero_length, saturated;

    function new();
      int i;
      mreg = REG_RESET;
      for (i = 0; i < 3; i++) begin
        box_lo[i] = '0;
        box_hi[i] = '0;
      end
    endfunction

    function void write_reg(int unsigned idx, logic [REG_W-1:0] val);
      if (idx < NUM_REGS) mreg[idx] = val;
    endfunction

    function logic signed [COORD_W-1:0] coef(int r, int c);
      logic [REG_W-1:0] w;
      w = mreg[r * 2 + c / 2];
      return (c % 2 == 1) ? w[COORD_W-1:0] : w[REG_W-1:COORD_W];
    endfunction

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned root, trial;
      int k;
      root = 0;
      for (k = 31; k >= 0; k--) begin
        trial = root | (64'd1 << k);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function void note_vertex(vertex_t v);
      vertex_result_t            res;
      logic signed [67:0]        acc;
      logic signed [COORD_W-1:0] tp [3];
      longint                    rn [3];
      longint unsigned           mag [3];
      longint unsigned           peak, sum_sq, len, q;
      longint                    nv;
      int                        r, j;
      res = '0;
      vertices++;
      for (r = 0; r < 3; r++) begin
        acc = 68'sd1 <<< (COORD_FRAC_BITS - 1);
        for (j = 0; j < 3; j++) acc = acc + coef(r, j) * $signed(v.pos[j]);
        acc = (acc >>> COORD_FRAC_BITS) + coef(r, 3);
        if (acc > 68'sh7FFF_FFFF) begin
          tp[r] = 32'h7FFF_FFFF;
          saturated++;
        end else if (acc < -68'sh8000_0000) begin
          tp[r] = 32'h8000_0000;
          saturated++;
        end else begin
          tp[r] = acc[COORD_W-1:0];
        end
      end

      if (v.has_normal) begin
        with_normal++;
        peak = 0;
        for (r = 0; r < 3; r++) begin
          rn[r] = 0;
          for (j = 0; j < 3; j++) rn[r] += longint'(coef(r, j)) * longint'($signed(v.nrm[j]));
          mag[r] = (rn[r] < 0) ? -rn[r] : rn[r];
          if (mag[r] > peak) peak = mag[r];
        end
        if (peak == 0) begin
          zero_length++;
        end else begin
          // common shift so the largest component lands just below 2^30
          while (peak >= (64'd1 << (NORM_PEAK_BIT + 1))) begin
            peak >>= 1;
            for (j = 0; j < 3; j++) mag[j] >>= 1;
          end
          while (peak < (64'd1 << NORM_PEAK_BIT)) begin
            peak <<= 1;
            for (j = 0; j < 3; j++) mag[j] <<= 1;
          end
          sum_sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
          len = sqrt_floor(sum_sq);
          for (j = 0; j < 3; j++) begin
            q = ((mag[j] << NORM_FRAC_BITS) + (len >> 1)) / len;
            nv = (rn[j] < 0) ? -longint'(q) : longint'(q);
            if (nv > 32767) nv = 32767;
            else if (nv < -32768) nv = -32768;
            res.nrm[j] = 16'(nv);
          end
        end
      end

      for (j = 0; j < 3; j++) begin
        if (v.first_vertex) begin
          box_lo[j] = tp[j];
          box_hi[j] = tp[j];
        end else begin
          if (tp[j] < box_lo[j]) box_lo[j] = tp[j];
          if (tp[j] > box_hi[j]) box_hi[j] = tp[j];
        end
        res.pos[j] = tp[j];
        res.lo[j]  = box_lo[j];
        res.hi[j]  = box_hi[j];
      end
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      vertex_result_t got, want;
      int i;
      got = vertex_result_t'(data);
      if (expected_q.size() == 0) begin
        report_mismatch("result arrived with no vertex outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      for (i = 0; i < 3; i++) begin
        if (got.pos[i] !== want.pos[i])
          report_mismatch($sformatf("result %0d pos[%0d] got %0d expected %0d", checked, i,
                                    $signed(got.pos[i]), $signed(want.pos[i])));
        if (got.nrm[i] !== want.nrm[i])
          report_mismatch($sformatf("result %0d norm[%0d] got %0d expected %0d", checked, i,
                                    $signed(got.nrm[i]), $signed(want.nrm[i])));
        if (got.lo[i] !== want.lo[i])
          report_mismatch($sformatf("result %0d box_min[%0d] got %0d expected %0d", checked, i,
                                    $signed(got.lo[i]), $signed(want.lo[i])));
        if (got.hi[i] !== want.hi[i])
          report_mismatch($sformatf("result %0d box_max[%0d] got %0d expected %0d", checked, i,
                                    $signed(got.hi[i]), $signed(want.hi[i])));
      end
    endtask
  endclass

  vertex_scoreboard sb = new();

  vertex_transform_bbox dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin : clock_gen
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic vertex_t vtx(bit first, logic [COORD_W-1:0] px, py, pz,
                                  bit has_n, logic [NORM_W-1:0] nx, ny, nz);
    vertex_t v;
    v.first_vertex = first;
    v.has_normal   = has_n;
    v.pos = {pz, py, px};
    v.nrm = {nz, ny, nx};
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(int unsigned pick);
    if (pick < 2) return $urandom;
    if (pick < 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return '0;
        default: return '1;
      endcase
    end
    return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
  endfunction

  function automatic vertex_t rand_vertex(bit first);
    vertex_t     v;
    int unsigned pos_pick, nrm_pick, i;
    v.first_vertex = first;
    v.has_normal   = ($urandom_range(0, 9) < 7);
    pos_pick = $urandom_range(0, 9);
    nrm_pick = $urandom_range(0, 11);
    for (i = 0; i < 3; i++) begin
      v.pos[i] = rand_coord(pos_pick);
      if (nrm_pick == 0) v.nrm[i] = '0;
      else if (nrm_pick < 4) v.nrm[i] = 16'($urandom);
      else if (nrm_pick == 4) v.nrm[i] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      else v.nrm[i] = 16'($urandom_range(0, 1 << 15)) - 16'(1 << 14);
    end
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] rand_entry(matrix_style_t style, bit shift_col);
    logic [COORD_W-1:0] base;
    case (style)
      STYLE_SMALL: begin
        if (shift_col) return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
        return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      end
      STYLE_ROTATION: begin
        case ($urandom_range(0, 4))
          0: base = '0;
          1: base = FX_ONE;
          2: base = -FX_ONE;
          3: base = FX_ONE >> 1;
          default: base = -(FX_ONE >> 1);
        endcase
        return base + 32'($urandom_range(0, 512)) - 32'd256;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic entry_grid_t rand_grid(matrix_style_t style);
    entry_grid_t g;
    foreach (g[r, c]) g[r][c] = rand_entry(style, c == 3);
    return g;
  endfunction

  function automatic entry_grid_t fill_grid(logic [COORD_W-1:0] val);
    entry_grid_t g;
    foreach (g[r, c]) g[r][c] = val;
    return g;
  endfunction

  task automatic send_vertex(vertex_t v);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) in_steady = !in_steady;
    gap = in_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {v.nrm, v.pos};
    in_tuser  <= {v.has_normal, v.first_vertex};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_vertex(v);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // unused indexes get junk data, the block must ignore it
  task automatic load_matrix(entry_grid_t g);
    matrix_regs_t     m;
    logic [REG_W-1:0] wdata;
    int               r, idx;
    for (r = 0; r < 3; r++) begin
      m[r * 2]     = {g[r][0], g[r][1]};
      m[r * 2 + 1] = {g[r][2], g[r][3]};
    end
    for (idx = 0; idx < (1 << REG_IDX_W); idx++) begin
      wdata = (idx < NUM_REGS) ? m[idx] : {$urandom, $urandom};
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(idx);
      cfg_wdata <= wdata;
      @(posedge clk);
      sb.write_reg(idx, wdata);
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  initial begin : stimulus
    entry_grid_t grid;
    int          phase, sent, mesh_len, k, r;
    bit          fresh;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity from reset; box grows from zero until the first mesh start
    send_vertex(vtx(0, 32'h0005_0000, 32'hFFFD_0000, '0, 0, 16'h1234, 16'h8000, 16'h7FFF));
    send_vertex(vtx(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 16'h4000, '0, '0));
    send_vertex(vtx(0, '0, '0, '0, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_vertex(vtx(1, 32'h8000_0000, 32'h7FFF_FFFF, '0, 1, 16'h8000, 16'h8000, 16'h8000));
    send_vertex(vtx(0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 1, '0, '0, '0));
    send_vertex(vtx(0, 32'h0064_0000, 32'h00C8_0000, 32'hFED4_0000, 1,
                    16'hC000, 16'h2000, 16'h0001));
    send_vertex(vtx(0, 32'hFFFF_8000, 32'h0000_7FFF, 32'h1234_5678, 1, '0, '0, 16'h0001));
    send_vertex(vtx(1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 16'hFFFF, 16'h0001, '0));
    send_vertex(vtx(0, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 0,
                    16'h4000, 16'h4000, 16'h4000));
    send_vertex(vtx(1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1,
                    16'h5555, 16'hAAAA, 16'h0F0F));
    send_vertex(vtx(0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 1,
                    16'hAAAA, 16'h5555, 16'hF0F0));
    wait_drained();

    load_matrix(fill_grid(32'h7FFF_FFFF));
    send_vertex(vtx(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                    16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_vertex(vtx(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                    16'h8000, 16'h7FFF, 16'h0000));
    send_vertex(vtx(0, 32'h0000_0001, '0, 32'hFFFF_FFFF, 1, 16'h0001, 16'hFFFF, '0));
    wait_drained();

    load_matrix(fill_grid(32'h8000_0000));
    send_vertex(vtx(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                    16'h8000, 16'h8000, 16'h8000));
    send_vertex(vtx(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                    16'h7FFF, 16'h8000, 16'h7FFF));
    send_vertex(vtx(0, '0, '0, '0, 0, '0, '0, '0));
    wait_drained();

    // half scale with unit shift back: odd positions land on rounding ties
    grid = fill_grid('0);
    for (r = 0; r < 3; r++) begin
      grid[r][r] = FX_ONE >> 1;
      grid[r][3] = -FX_ONE;
    end
    load_matrix(grid);
    send_vertex(vtx(1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 1,
                    16'h0003, 16'hFFFD, 16'h0001));
    send_vertex(vtx(0, 32'hFFFF_FFFD, 32'h0001_0001, 32'h8000_0001, 1,
                    16'h2000, 16'h2000, 16'h2000));
    send_vertex(vtx(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0,
                    16'h1111, 16'h2222, 16'h3333));
    wait_drained();

    // zero matrix turns every normal into a zero-length one
    load_matrix(fill_grid('0));
    send_vertex(vtx(1, 32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 1,
                    16'h7FFF, 16'h8000, 16'h4000));
    send_vertex(vtx(0, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1,
                    16'h0001, 16'h0001, 16'h0001));

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      load_matrix(rand_grid(matrix_style_t'(phase % 3)));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        mesh_len = $urandom_range(1, 24);
        fresh = ($urandom_range(0, 9) != 0);
        for (k = 0; k < mesh_len; k++) begin
          send_vertex(rand_vertex(fresh && k == 0));
          sent++;
        end
      end
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d vertices, %0d with a normal (%0d of zero length), %0d matrices",
             sb.vertices, sb.with_normal, sb.zero_length, settings_loaded + 1);
    $display("%0d results checked, %0d saturated coordinates, %0d mismatches",
             sb.checked, sb.saturated, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) out_steady = !out_steady;
      gap = out_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  // no item moving on either stream for too long means the block is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results outstanding",
               idle_cycles, sb.expected_q.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> vertex_transform_bbox.f
+incdir+sv
sv/vtb_pkg.sv
sv/vtb_mul.sv
sv/vtb_csub.sv
sv/vertex_transform_bbox.sv
test/vertex_transform_bbox_tb.sv
